// ===== design/hrrn_pkg.sv =====
// Shared types and constants for the HRRN scheduler.
// No dependencies; imported by hrrn_slot_mem and hrrn_cpu_scheduler.
package hrrn_pkg;

  // Default sizing
  localparam int MAX_PROCS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 16;

  // Action codes of an input word
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ARRIVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // Per-slot process state
  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_WAITING    = 3'd1,
    ST_READY      = 3'd2,
    ST_RUNNING    = 3'd3,
    ST_TERMINATED = 3'd4
  } slot_state_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_EV,
    S_A_EV,
    S_A_CMP,
    S_A_END,
    S_B_EV,
    S_B_CMP,
    S_B_END,
    S_DONE
  } fsm_state_t;

endpackage

// ===== design/hrrn_req_if.sv =====
// Request channel: one input word (action, slot, burst) with valid/ready.
// Depends on nothing.
interface hrrn_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  slot;
  logic [15:0] burst;

  modport source (output valid, action, slot, burst, input ready);
  modport sink   (input valid, action, slot, burst, output ready);
endinterface

// ===== design/hrrn_rsp_if.sv =====
// Response channel: scheduler status word with valid/ready.
// Depends on nothing.
interface hrrn_rsp_if;
  logic        valid;
  logic        ready;
  logic        running_valid;
  logic [3:0]  running_slot;
  logic [15:0] remaining;
  logic        finished_valid;
  logic [3:0]  finished_slot;
  logic [31:0] clock_count;
  logic [31:0] idle_count;

  modport source (output valid, running_valid, running_slot, remaining,
                  finished_valid, finished_slot, clock_count, idle_count,
                  input ready);
  modport sink   (input valid, running_valid, running_slot, remaining,
                  finished_valid, finished_slot, clock_count, idle_count,
                  output ready);
endinterface

// ===== design/hrrn_slot_mem.sv =====
// Slot table: one-port-write, one-port-read synchronous memory, registered read.
// Per-entry valid flops make unwritten entries read as empty. Uses hrrn_pkg.
module hrrn_slot_mem
  import hrrn_pkg::*;
#(
  parameter int DEPTH = MAX_PROCS_DEF,
  parameter int AW    = $clog2(MAX_PROCS_DEF),
  parameter int TW    = TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_state_t   wr_status,
  input  logic [TW-1:0] wr_burst,
  input  logic [TW-1:0] wr_rem,
  input  logic [TW-1:0] wr_wait,
  input  logic [AW-1:0] rd_addr,
  output slot_state_t   rd_status,
  output logic [TW-1:0] rd_burst,
  output logic [TW-1:0] rd_rem,
  output logic [TW-1:0] rd_wait
);

  localparam int WW = 3 + 3 * TW;

  logic [WW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WW-1:0]    wdata;
  logic [WW-1:0]    rd_q;
  logic             rd_vld;

  assign wdata = {wr_status, wr_burst, wr_rem, wr_wait};

  // Array write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  // Registered read, write data forwarded on an address match
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entry valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= (wr_en && wr_addr == rd_addr) || vld[rd_addr];
    end
  end

  assign rd_status = rd_vld ? slot_state_t'(rd_q[WW-1 -: 3]) : ST_EMPTY;
  assign rd_burst  = rd_q[3*TW-1 -: TW];
  assign rd_rem    = rd_q[2*TW-1 -: TW];
  assign rd_wait   = rd_q[TW-1:0];

endmodule

// ===== design/hrrn_cpu_scheduler.sv =====
// Non-preemptive highest-response-ratio-next scheduler, top level.
// Uses hrrn_pkg, hrrn_req_if, hrrn_rsp_if and hrrn_slot_mem.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | action, slot, burst                       | valid/ready
//  rsp     | out | running/finished slot, remaining, counts  | valid/ready
//
// Load and arrival go through table read, write back and result.
// A tick walks the slot table over the single read port, each slot in an
// evaluate and a compare state, once to dispatch when the CPU is idle and
// once, if a process is then running, to age waits and pick a successor.
// rst is synchronous; every slot reads empty right after it, no clearing pass.
// req.ready is high in the idle state; a result waiting on rsp does not block it.
module hrrn_cpu_scheduler
  import hrrn_pkg::*;
#(
  parameter int MAX_PROCS  = MAX_PROCS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  hrrn_req_if.sink req,
  hrrn_rsp_if.source rsp
);

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TW = TIME_WIDTH;
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_PROCS - 1);
  localparam logic [TW-1:0] TMAX = '1;

  fsm_state_t state, state_next;

  // captured request
  logic [1:0]    act;
  logic [SW-1:0] sl_idx;
  logic [TW-1:0] bur;

  // scan and selection
  logic [SW-1:0]   idx;
  logic            found;
  logic [SW-1:0]   best_idx;
  logic [TW-1:0]   best_burst, best_rem, best_wait;
  logic            cand_ready;
  logic [TW-1:0]   cand_burst, cand_rem, cand_wait;
  logic [2*TW-1:0] lhs, rhs;
  logic            take;

  // CPU state and counters
  logic          cur_valid;
  logic [SW-1:0] cur_slot;
  logic [TW-1:0] cur_rem;
  logic          fin;
  logic [SW-1:0] fin_slot;
  logic [31:0]   tick_cnt, idle_cnt;

  // memory ports
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  slot_state_t   wr_status;
  logic [TW-1:0] wr_burst, wr_rem, wr_wait;
  logic [SW-1:0] rd_addr;
  slot_state_t   rd_status;
  logic [TW-1:0] rd_burst, rd_rem, rd_wait;

  // request decode
  logic          slot_ok;
  logic [31:0]   b32;
  logic [TW-1:0] b_sat;
  logic          out_free;

  // aging pass
  logic          is_cur;
  logic [TW-1:0] w_n, rem_n, ev_wait;
  logic          term;

  hrrn_slot_mem #(.DEPTH(MAX_PROCS), .AW(SW), .TW(TW)) u_mem (
    .clk, .rst,
    .wr_en, .wr_addr, .wr_status, .wr_burst, .wr_rem, .wr_wait,
    .rd_addr, .rd_status, .rd_burst, .rd_rem, .rd_wait
  );

  assign slot_ok  = (int'(req.slot) < MAX_PROCS);
  assign b32      = 32'(req.burst);
  assign b_sat    = TW'((b32 > 32'(TMAX)) ? 32'(TMAX) : b32);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // aging of one entry during the second pass
  assign is_cur  = (idx == cur_slot);
  assign w_n     = (rd_status == ST_READY && rd_wait != TMAX) ? rd_wait + 1'b1 : rd_wait;
  assign rem_n   = (is_cur && rd_rem != '0) ? rd_rem - 1'b1 : rd_rem;
  assign term    = is_cur && rem_n == '0;
  assign ev_wait = (state == S_B_EV) ? w_n : rd_wait;

  // ranking: candidate beats best on higher ratio, then smaller burst
  assign take = cand_ready &&
                (!found || lhs < rhs || (lhs == rhs && best_burst > cand_burst));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_status  = rd_status;
    wr_burst   = rd_burst;
    wr_rem     = rd_rem;
    wr_wait    = rd_wait;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          rd_addr = SW'(req.slot);
          if ((req.action == ACT_LOAD || req.action == ACT_ARRIVE) && slot_ok) begin
            state_next = S_ACC_EV;
          end else if (req.action == ACT_TICK) begin
            rd_addr    = '0;
            state_next = cur_valid ? S_B_EV : S_A_EV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ACC_EV: begin
        wr_addr = sl_idx;
        if (act == ACT_LOAD) begin
          // zero burst or a busy slot leaves the table alone
          if (bur != '0 && rd_status != ST_READY && rd_status != ST_RUNNING) begin
            wr_en     = 1'b1;
            wr_status = ST_WAITING;
            wr_burst  = bur;
            wr_rem    = bur;
            wr_wait   = '0;
          end
        end else if (rd_status == ST_WAITING) begin
          wr_en     = 1'b1;
          wr_status = ST_READY;
        end
        state_next = S_DONE;
      end
      S_A_EV: state_next = S_A_CMP;
      S_A_CMP: begin
        rd_addr = idx + 1'b1;
        state_next = (idx == LAST_IDX) ? S_A_END : S_A_EV;
      end
      S_A_END: begin
        if (found) begin
          wr_en      = 1'b1;
          wr_addr    = best_idx;
          wr_status  = ST_RUNNING;
          wr_burst   = best_burst;
          wr_rem     = best_rem;
          wr_wait    = best_wait;
          rd_addr    = '0;
          state_next = S_B_EV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_B_EV: begin
        wr_en      = (rd_status == ST_READY) || is_cur;
        wr_status  = term ? ST_TERMINATED : rd_status;
        wr_rem     = rem_n;
        wr_wait    = w_n;
        state_next = S_B_CMP;
      end
      S_B_CMP: begin
        rd_addr = idx + 1'b1;
        state_next = (idx == LAST_IDX) ? S_B_END : S_B_EV;
      end
      S_B_END: begin
        if (fin && found) begin
          wr_en     = 1'b1;
          wr_addr   = best_idx;
          wr_status = ST_RUNNING;
          wr_burst  = best_burst;
          wr_rem    = best_rem;
          wr_wait   = best_wait;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act    <= req.action;
        sl_idx <= SW'(req.slot);
        bur    <= b_sat;
        idx    <= '0;
      end
      S_A_EV, S_B_EV: begin
        cand_ready <= (rd_status == ST_READY);
        cand_burst <= rd_burst;
        cand_rem   <= rd_rem;
        cand_wait  <= ev_wait;
        lhs        <= best_wait * rd_burst;
        rhs        <= ev_wait * best_burst;
      end
      S_A_CMP, S_B_CMP: begin
        if (take) begin
          best_idx   <= idx;
          best_burst <= cand_burst;
          best_rem   <= cand_rem;
          best_wait  <= cand_wait;
        end
        idx <= idx + 1'b1;
      end
      S_A_END: idx <= '0;
      default: ;
    endcase
  end

  // control state, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      found              <= 1'b0;
      cur_valid          <= 1'b0;
      cur_slot           <= '0;
      cur_rem            <= '0;
      fin                <= 1'b0;
      fin_slot           <= '0;
      tick_cnt           <= '0;
      idle_cnt           <= '0;
      rsp.valid          <= 1'b0;
      rsp.running_valid  <= 1'b0;
      rsp.running_slot   <= '0;
      rsp.remaining      <= '0;
      rsp.finished_valid <= 1'b0;
      rsp.finished_slot  <= '0;
      rsp.clock_count    <= '0;
      rsp.idle_count     <= '0;
    end else begin
      // drop valid once taken, unless a new word is loaded this cycle
      if (rsp.valid && rsp.ready && !(state == S_DONE && out_free)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            fin      <= 1'b0;
            fin_slot <= '0;
            found    <= 1'b0;
          end
        end
        S_A_CMP, S_B_CMP: begin
          if (take) begin
            found <= 1'b1;
          end
        end
        S_A_END: begin
          if (found) begin
            cur_valid <= 1'b1;
            cur_slot  <= best_idx;
            cur_rem   <= best_rem;
            found     <= 1'b0;
          end else begin
            cur_slot <= '0;
            tick_cnt <= tick_cnt + 1'b1;
            idle_cnt <= idle_cnt + 1'b1;
          end
        end
        S_B_EV: begin
          if (is_cur) begin
            cur_rem <= rem_n;
          end
          if (term) begin
            fin      <= 1'b1;
            fin_slot <= idx;
          end
        end
        S_B_END: begin
          tick_cnt <= tick_cnt + 1'b1;
          if (fin) begin
            if (found) begin
              cur_slot <= best_idx;
              cur_rem  <= best_rem;
            end else begin
              cur_valid <= 1'b0;
              cur_slot  <= '0;
              idle_cnt  <= idle_cnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid          <= 1'b1;
            rsp.running_valid  <= cur_valid;
            rsp.running_slot   <= cur_valid ? 4'(cur_slot) : 4'd0;
            rsp.remaining      <= cur_valid ? 16'(cur_rem) : 16'd0;
            rsp.finished_valid <= fin;
            rsp.finished_slot  <= fin ? 4'(fin_slot) : 4'd0;
            rsp.clock_count    <= tick_cnt;
            rsp.idle_count     <= idle_cnt;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a running slot between items always has time left
  a_run_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cur_valid) |-> cur_rem != '0)
    else $error("running slot with zero remaining time");

  // the slot that just finished is never the one dispatched after it
  a_fin_not_cur: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && fin && cur_valid) |-> cur_slot != fin_slot)
    else $error("finished slot still on the CPU");

  // an accepted word always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != S_IDLE)
    else $error("accepted word did not start the sequencer");

  // a finish is only reported on a tick
  a_fin_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && fin) |-> act == ACT_TICK)
    else $error("finish reported outside a tick");
`endif

endmodule
